// ===== hw/rtl/ppe_pkg.sv =====
`default_nettype none
package ppe_pkg;

  // Plane geometry: one memory entry holds the byte of all four planes.
  localparam int PlaneBytes = 65536;
  localparam int AddrW      = $clog2(PlaneBytes);
  localparam int NumPlanes  = 4;
  localparam int WordW      = 8 * NumPlanes;

  // Field widths.
  localparam int XW     = 13;
  localparam int YW     = 12;
  localparam int ColorW = 4;
  localparam int OpW    = 2;
  localparam int LineW  = 11;

  localparam logic [LineW-1:0] LineOffsetReset = LineW'(80);

  // Item kinds.
  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // Write functions.
  typedef enum logic [OpW-1:0] {
    OpSet = 2'd0,
    OpXor = 2'd1,
    OpOr  = 2'd2,
    OpAnd = 2'd3
  } op_e;

  // One request as it arrives.
  typedef struct packed {
    logic              action;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [ColorW-1:0] color;
    logic [OpW-1:0]    op;
  } req_t;

  // One request after address generation.
  typedef struct packed {
    logic              action;
    logic [AddrW-1:0]  addr;
    logic [2:0]        bitpos;
    logic [ColorW-1:0] color;
    logic [OpW-1:0]    op;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppe_if.sv =====
`default_nettype none
// Request channel: one pixel access per transfer.
interface ppe_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ppe_pkg::XW-1:0]      x;
  logic [ppe_pkg::YW-1:0]      y;
  logic [ppe_pkg::ColorW-1:0]  color;
  logic [ppe_pkg::OpW-1:0]     op;

  modport source (output valid, output action, output x, output y, output color,
                  output op, input ready);
  modport sink   (input valid, input action, input x, input y, input color,
                  input op, output ready);
endinterface

// Response channel: one colour per transfer, from reads only.
interface ppe_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ppe_pkg::ColorW-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppe_ram.sv =====
`default_nettype none
module ppe_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ppe_agen.sv =====
`default_nettype none
module ppe_agen (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire ppe_pkg::req_t               req_i,
  input  wire logic [ppe_pkg::LineW-1:0]   line_offset_i,
  output ppe_pkg::job_t                    job_o
);

  localparam int ProdW = ppe_pkg::YW + ppe_pkg::LineW;

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] sum;
  ppe_pkg::job_t    job_d, job_q;

  // Byte address: row times line offset plus column byte, wrapped to the plane.
  assign prod = ProdW'(req_i.y) * ProdW'(line_offset_i);
  assign sum  = prod + ProdW'(req_i.x[ppe_pkg::XW-1:3]);

  always_comb begin
    job_d.action = req_i.action;
    job_d.addr   = sum[ppe_pkg::AddrW-1:0];
    job_d.bitpos = 3'd7 - req_i.x[2:0];
    job_d.color  = req_i.color;
    job_d.op     = req_i.op;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_d;
    end
  end

  assign job_o = job_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ppe_rmw.sv =====
`default_nettype none
module ppe_rmw (
  input  wire ppe_pkg::job_t                  job_i,
  input  wire logic [ppe_pkg::WordW-1:0]      word_i,
  output logic      [ppe_pkg::WordW-1:0]      word_o,
  output logic      [ppe_pkg::ColorW-1:0]     pixel_o
);

  logic [4:0] idx;
  logic       old_bit;
  logic       new_bit;
  logic       col_bit;

  // Pick the addressed bit in each plane byte, gather it, and merge the new one.
  always_comb begin
    word_o  = word_i;
    pixel_o = '0;
    idx     = '0;
    old_bit = 1'b0;
    new_bit = 1'b0;
    col_bit = 1'b0;
    for (int n = 0; n < ppe_pkg::NumPlanes; n++) begin
      idx     = 5'(8 * n) + {2'b00, job_i.bitpos};
      old_bit = word_i[idx];
      col_bit = job_i.color[n];
      case (ppe_pkg::op_e'(job_i.op))
        ppe_pkg::OpSet: new_bit = col_bit;
        ppe_pkg::OpXor: new_bit = old_bit ^ col_bit;
        ppe_pkg::OpOr:  new_bit = old_bit | col_bit;
        ppe_pkg::OpAnd: new_bit = old_bit & col_bit;
        default:        new_bit = col_bit;
      endcase
      word_o[idx] = new_bit;
      pixel_o[n]  = old_bit;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/planar_pixel_engine.sv =====
`default_nettype none
// Each request passes through address generation, plane memory read, then
// write-back or result. A read's colour is registered in the result step and offered
// from then on; a write gives no result. No new request is taken until the last one
// is through, since ready is high only in the idle state; a colour still waiting
// holds the next read in its result step. Reset clears control
// state and sets the line offset to 80; plane memory is not cleared.
module planar_pixel_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ppe_pkg::LineW-1:0]  cfg_wdata_i,
  ppe_req_if.sink                         req_i,
  ppe_rsp_if.source                       rsp_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                  state_d, state_q;
  logic [ppe_pkg::LineW-1:0]   line_offset_q;
  logic                        rsp_valid_d, rsp_valid_q;
  logic [ppe_pkg::ColorW-1:0]  pixel_q;

  ppe_pkg::req_t               req;
  ppe_pkg::job_t               job;
  logic                        accept;
  logic                        mem_re;
  logic                        mem_we;
  logic                        rsp_load;
  logic [ppe_pkg::WordW-1:0]   rd_word;
  logic [ppe_pkg::WordW-1:0]   wr_word;
  logic [ppe_pkg::ColorW-1:0]  pixel;

  // Line offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_offset_q <= ppe_pkg::LineOffsetReset;
    end else if (cfg_we_i) begin
      line_offset_q <= cfg_wdata_i;
    end
  end

  // Request transfer.
  assign req.action  = req_i.action;
  assign req.x       = req_i.x;
  assign req.y       = req_i.y;
  assign req.color   = req_i.color;
  assign req.op      = req_i.op;
  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  ppe_agen u_agen (
    .clk_i         (clk_i),
    .load_i        (accept),
    .req_i         (req),
    .line_offset_i (line_offset_q),
    .job_o         (job)
  );

  ppe_ram #(
    .Width (ppe_pkg::WordW),
    .Depth (ppe_pkg::PlaneBytes)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (job.addr),
    .wdata_i (wr_word),
    .re_i    (mem_re),
    .raddr_i (job.addr),
    .rdata_o (rd_word)
  );

  ppe_rmw u_rmw (
    .job_i   (job),
    .word_i  (rd_word),
    .word_o  (wr_word),
    .pixel_o (pixel)
  );

  // Sequencer: read the entry, then write it back or hand over the colour.
  always_comb begin
    state_d  = state_q;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    rsp_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRead;
        end
      end
      StRead: begin
        mem_re  = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (job.action == ppe_pkg::ActWrite) begin
          mem_we  = 1'b1;
          state_d = StIdle;
        end else if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: holds a colour until its transfer.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      pixel_q <= pixel;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.pixel = pixel_q;

endmodule
`default_nettype wire

// ===== sim/ppe_plane_check.sv =====
`timescale 1ns / 100ps
// Watches the request, response and line offset ports of the pixel engine,
// keeps its own copy of the four bit planes and checks every colour read back.
module ppe_plane_check
  import ppe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LineW-1:0] cfg_wdata_i,
  ppe_req_if               req,
  ppe_rsp_if               rsp,
  output int               fail_count_o,
  output int               pending_o
);

  logic [LineW-1:0]  line_offset;
  // One entry per byte address, plane n in bits 8n+7..8n.
  logic [WordW-1:0]  plane_mem [int];
  logic [ColorW-1:0] expected_pixels [$];
  int                mismatches;

  // Byte address of a pixel, wrapping at the plane size.
  function automatic int pixel_byte(logic [XW-1:0] x, logic [YW-1:0] y,
                                    logic [LineW-1:0] lo);
    return (int'(y) * int'(lo) + int'(x >> 3)) % PlaneBytes;
  endfunction

  // Everything is sampled at the clock edge, so only pre-edge values are seen.
  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [WordW-1:0]  word;
    logic [ColorW-1:0] pix;
    logic              old_bit;
    logic              new_bit;
    int                a;
    int                bp;
    if (!rst_ni) begin
      line_offset = LineOffsetReset;
      expected_pixels.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        line_offset = cfg_wdata_i;
      end

      // Compare a returned colour with the oldest one outstanding.
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: pixel %0d returned with no read outstanding", $time, rsp.pixel);
          end
        end else begin
          pix = expected_pixels.pop_front();
          if (rsp.pixel !== pix) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: pixel mismatch, expected %0d, got %0d", $time, pix, rsp.pixel);
            end
          end
        end
      end

      // Work out the effect of each request transfer on the planes.
      if (req.valid && req.ready) begin
        a = pixel_byte(req.x, req.y, line_offset);
        bp = 7 - int'(req.x[2:0]);
        word = plane_mem.exists(a) ? plane_mem[a] : '0;
        if (req.action == ActRead) begin
          for (int n = 0; n < NumPlanes; n++) begin
            pix[n] = word[8*n + bp];
          end
          expected_pixels.push_back(pix);
        end else begin
          for (int n = 0; n < NumPlanes; n++) begin
            old_bit = word[8*n + bp];
            case (op_e'(req.op))
              OpSet:   new_bit = req.color[n];
              OpXor:   new_bit = old_bit ^ req.color[n];
              OpOr:    new_bit = old_bit | req.color[n];
              default: new_bit = old_bit & req.color[n];
            endcase
            word[8*n + bp] = new_bit;
          end
          plane_mem[a] = word;
        end
      end

      fail_count_o <= mismatches;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

// ===== sim/tb_planar_pixel_engine.sv =====
`timescale 1ns / 100ps
module tb_planar_pixel_engine;
  import ppe_pkg::*;

  typedef struct {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } spot_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [LineW-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               idle_tx;
  int               idle_rx;
  logic [LineW-1:0] cur_lo;
  // Pixels set since reset, one mask of bit positions per byte address.
  bit [7:0]         written_mask [int];
  spot_t            recent [$];

  ppe_req_if req_ch ();
  ppe_rsp_if rsp_ch ();

  planar_pixel_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  ppe_plane_check u_plane_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The response side stalls at random according to the current phase.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(0, 99) >= idle_rx);
    end
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("tb_planar_pixel_engine: FAIL");
    $finish;
  end

  function automatic int byte_at(logic [XW-1:0] x, logic [YW-1:0] y);
    return (int'(y) * int'(cur_lo) + int'(x >> 3)) % PlaneBytes;
  endfunction

  function automatic bit is_written(logic [XW-1:0] x, logic [YW-1:0] y);
    int a;
    a = byte_at(x, y);
    return written_mask.exists(a) && written_mask[a][7 - int'(x[2:0])];
  endfunction

  function automatic req_t mk(logic act, int x, int y, int color, op_e op);
    req_t r;
    r.action = act;
    r.x = XW'(x);
    r.y = YW'(y);
    r.color = ColorW'(color);
    r.op = op;
    return r;
  endfunction

  // Offers one request and holds it until the transfer. A pixel only counts as
  // known once a set has landed on it, since the other functions use the old bit.
  task automatic send_item(input req_t r);
    int a;
    spot_t s;
    if (r.action == ActWrite && (r.op == OpSet || is_written(r.x, r.y))) begin
      a = byte_at(r.x, r.y);
      if (!written_mask.exists(a)) begin
        written_mask[a] = '0;
      end
      written_mask[a][7 - int'(r.x[2:0])] = 1'b1;
      s.x = r.x;
      s.y = r.y;
      recent.push_back(s);
      if (recent.size() > 64) begin
        void'(recent.pop_front());
      end
    end
    while ($urandom_range(0, 99) < idle_tx) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.x <= r.x;
    req_ch.y <= r.y;
    req_ch.color <= r.color;
    req_ch.op <= r.op;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Waits until every read has returned and any write has left the pipeline.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_line_offset(input logic [LineW-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_lo = value;
  endtask

  initial begin
    req_t             r;
    int               roll;
    int               k;
    logic [LineW-1:0] seg_lo [6];

    idle_tx = 0;
    idle_rx = 0;
    cur_lo = LineOffsetReset;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= ActRead;
    req_ch.x <= '0;
    req_ch.y <= '0;
    req_ch.color <= '0;
    req_ch.op <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset line offset: field extremes, every write
    // function, reads straight after writes, and an address that wraps.
    send_item(mk(ActWrite, 0, 0, 15, OpSet));
    send_item(mk(ActRead, 0, 0, 0, OpSet));
    send_item(mk(ActWrite, 8191, 4095, 5, OpSet));
    send_item(mk(ActRead, 8191, 4095, 0, OpSet));
    send_item(mk(ActWrite, 8191, 4095, 3, OpXor));
    send_item(mk(ActRead, 8191, 4095, 0, OpSet));
    send_item(mk(ActWrite, 8191, 4095, 8, OpOr));
    send_item(mk(ActRead, 8191, 4095, 0, OpSet));
    send_item(mk(ActWrite, 8191, 4095, 9, OpAnd));
    send_item(mk(ActRead, 8191, 4095, 0, OpSet));
    send_item(mk(ActWrite, 1, 0, 10, OpSet));
    send_item(mk(ActRead, 1, 0, 0, OpSet));
    send_item(mk(ActRead, 0, 0, 15, OpAnd));
    send_item(mk(ActWrite, 0, 820, 7, OpSet));
    send_item(mk(ActRead, 512, 0, 15, OpXor));
    send_item(mk(ActRead, 0, 820, 0, OpOr));

    // Random part in six stretches, each with its own line offset, the
    // out-of-range values among them. Idling changes every two stretches.
    seg_lo[0] = LineW'(1);
    seg_lo[1] = LineW'(1024);
    seg_lo[2] = LineW'(0);
    seg_lo[3] = LineW'(2047);
    seg_lo[4] = LineW'($urandom_range(1, 1024));
    seg_lo[5] = LineOffsetReset;
    for (int seg = 0; seg < 6; seg++) begin
      set_line_offset(seg_lo[seg]);
      case (seg / 2)
        0: begin
          idle_tx = 27;
          idle_rx = 70;
        end
        1: begin
          idle_tx = 70;
          idle_rx = 27;
        end
        default: begin
          idle_tx = 0;
          idle_rx = 0;
        end
      endcase
      for (int i = 0; i < 150; i++) begin
        r.action = ActWrite;
        r.x = XW'($urandom_range(0, 8191));
        r.y = YW'($urandom_range(0, 4095));
        r.color = ColorW'($urandom_range(0, 15));
        r.op = OpW'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        // Mostly revisit a recent pixel or a neighbour in the same byte.
        if (recent.size() > 0 && roll < 70) begin
          k = recent.size() - 1
              - $urandom_range(0, (recent.size() > 8) ? 7 : recent.size() - 1);
          r.x = recent[k].x;
          r.y = recent[k].y;
          if (roll >= 45) begin
            r.x[2:0] = 3'($urandom_range(0, 7));
          end
        end
        if ((roll < 55 || roll >= 90) && is_written(r.x, r.y)) begin
          r.action = ActRead;
        end
        send_item(r);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_planar_pixel_engine: PASS");
    end else begin
      $display("tb_planar_pixel_engine: FAIL");
    end
    $finish;
  end

endmodule
